/* sv/sts_pkg.sv */
// types, constants and sizes shared by the scroll sequencer modules
package sts_pkg;

   localparam int MSG_DEPTH    = 512;
   localparam int MODULE_COUNT = 5;

   localparam int ADDR_W     = $clog2(MSG_DEPTH);
   localparam int SEND_COUNT = (MODULE_COUNT - 1) * 2;
   localparam int WIN_LEN    = SEND_COUNT + 3;
   localparam int SENT_W     = $clog2(WIN_LEN);

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_TICK = 2'd1;
   localparam logic [1:0] MODE_DONE = 2'd2;

   localparam logic [7:0] MARKER_BYTE = 8'd7;
   localparam logic [7:0] DASH_CHAR   = 8'h2D;
   localparam logic [3:0] LAST_COLUMN = 4'd9;
   localparam logic [7:0] DOWN_PACE   = 8'd4;
   localparam logic [7:0] UP_PACE     = 8'd1;
   localparam logic [1:0] HOLD_FRAMES = 2'd2;
   localparam logic [7:0] PACE_RESET  = 8'd16;

   typedef struct packed {
      logic [1:0] mode;
      logic [8:0] load_address;
      logic [7:0] load_byte;
   } sts_req_type;

   typedef struct packed {
      logic       send_strobe;
      logic [7:0] send_byte;
      logic       select_active;
      logic [7:0] left_char;
      logic [7:0] right_char;
      logic [3:0] sweep_column;
      logic       normal_running;
   } sts_rsp_type;

   typedef logic [WIN_LEN-1:0][7:0] sts_win_type;

   typedef struct packed {
      logic              load_en;
      logic [ADDR_W-1:0] load_addr;
      logic [7:0]        load_byte;
      logic              advance;
      logic              restart;
   } sts_win_cmd_type;

endpackage

/* sv/sts_window.sv */
// message store, text position and the cached window of bytes ahead of it
module sts_window (
   input  logic                     clock,
   input  logic                     reset,
   input  sts_pkg::sts_win_cmd_type cmd,
   output sts_pkg::sts_win_type     win
);

   logic [7:0]                  store_ff [sts_pkg::MSG_DEPTH];
   logic [7:0]                  rdata_ff;
   logic [sts_pkg::ADDR_W-1:0]  pos_ff;
   logic [sts_pkg::ADDR_W-1:0]  pos_in;
   logic [sts_pkg::ADDR_W-1:0]  raddr;
   logic                        rhit;
   sts_pkg::sts_win_type        win_ff;
   sts_pkg::sts_win_type        win_in;
   sts_pkg::sts_win_type        zero_ff;
   sts_pkg::sts_win_type        zero_in;
   sts_pkg::sts_win_type        shifted;
   sts_pkg::sts_win_type        base;

   always_comb begin
      if (cmd.restart) begin
         pos_in = '0;
      end else if (cmd.advance) begin
         pos_in = pos_ff + sts_pkg::ADDR_W'(1);
      end else begin
         pos_in = pos_ff;
      end
      raddr   = pos_in + sts_pkg::ADDR_W'(sts_pkg::WIN_LEN);
      rhit    = cmd.load_en && (cmd.load_addr == raddr);
      shifted = {rdata_ff, win_ff[sts_pkg::WIN_LEN-1:1]};
      for (int i = 0; i < sts_pkg::WIN_LEN; i++) begin
         // fixed copy of the first bytes, used when the text restarts
         zero_in[i] = (cmd.load_en && cmd.load_addr == sts_pkg::ADDR_W'(i)) ?
                      cmd.load_byte : zero_ff[i];
      end
      if (cmd.restart) begin
         base = zero_in;
      end else if (cmd.advance) begin
         base = shifted;
      end else begin
         base = win_ff;
      end
      for (int i = 0; i < sts_pkg::WIN_LEN; i++) begin
         win_in[i] = (cmd.load_en && cmd.load_addr == pos_in + sts_pkg::ADDR_W'(i)) ?
                     cmd.load_byte : base[i];
      end
   end

   // lookahead byte is always the one just past the window
   always_ff @(posedge clock) begin
      if (cmd.load_en) begin
         store_ff[cmd.load_addr] <= cmd.load_byte;
      end
      rdata_ff <= rhit ? cmd.load_byte : store_ff[raddr];
      win_ff   <= win_in;
      zero_ff  <= zero_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   assign win = win_ff;

endmodule

/* sv/sts_control.sv */
// sweep and scroll control: pacing, push sequence, hold and latched characters
module sts_control (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  sts_pkg::sts_req_type     req,
   input  logic [7:0]               pace_cfg,
   input  sts_pkg::sts_win_type     win,
   output sts_pkg::sts_win_cmd_type cmd,
   output sts_pkg::sts_rsp_type     result
);

   logic                       phase_ff, phase_in;
   logic                       down_ff, down_in;
   logic [7:0]                 pace_ff, pace_in;
   logic [3:0]                 col_ff, col_in;
   logic [sts_pkg::SENT_W-1:0] sent_ff, sent_in;
   logic [1:0]                 hold_ff, hold_in;
   logic [7:0]                 left_ff, left_in;
   logic [7:0]                 right_ff, right_in;
   logic                       select_ff, select_in;
   logic [7:0]                 pace_dec;
   logic [3:0]                 col_next;
   logic [sts_pkg::SENT_W-1:0] sent_eff;
   logic                       push;
   logic                       strobe;
   logic [7:0]                 sent_byte;

   always_comb begin
      phase_in  = phase_ff;
      down_in   = down_ff;
      pace_in   = pace_ff;
      col_in    = col_ff;
      sent_in   = sent_ff;
      hold_in   = hold_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      select_in = select_ff;
      strobe    = 1'b0;
      sent_byte = '0;
      push      = 1'b0;
      sent_eff  = sent_ff;
      pace_dec  = pace_ff - 8'd1;
      col_next  = down_ff ? col_ff - 4'd1 : col_ff + 4'd1;
      cmd           = '0;
      cmd.load_en   = fire && (req.mode == sts_pkg::MODE_LOAD);
      cmd.load_addr = sts_pkg::ADDR_W'(req.load_address);
      cmd.load_byte = req.load_byte;

      if (fire) begin
         unique case (req.mode)
            sts_pkg::MODE_LOAD: begin
            end
            sts_pkg::MODE_TICK: begin
               pace_in = pace_dec;
               if (pace_dec == 8'd0) begin
                  if (!phase_ff) begin
                     col_in  = col_next;
                     pace_in = down_ff ? sts_pkg::DOWN_PACE : sts_pkg::UP_PACE;
                     if (col_next == sts_pkg::LAST_COLUMN) begin
                        down_in = 1'b1;
                     end
                     if (col_next == 4'd0) begin
                        phase_in    = 1'b1;
                        down_in     = 1'b0;
                        pace_in     = pace_cfg;
                        left_in     = sts_pkg::DASH_CHAR;
                        right_in    = sts_pkg::DASH_CHAR;
                        cmd.restart = 1'b1;
                     end
                  end else begin
                     pace_in  = pace_cfg;
                     sent_eff = '0;
                     push     = 1'b1;
                  end
               end
            end
            sts_pkg::MODE_DONE: begin
               push = select_ff;
            end
            default: begin
            end
         endcase
      end

      if (push) begin
         if (sent_eff < sts_pkg::SENT_W'(sts_pkg::SEND_COUNT)) begin
            select_in = 1'b1;
            strobe    = 1'b1;
            sent_byte = win[sent_eff];
            sent_in   = sent_eff + sts_pkg::SENT_W'(1);
         end else begin
            select_in = 1'b0;
            left_in   = win[sts_pkg::SEND_COUNT];
            right_in  = win[sts_pkg::SEND_COUNT+1];
            sent_in   = sent_eff + sts_pkg::SENT_W'(2);
            priority if (hold_ff != 2'd0) begin
               hold_in     = hold_ff - 2'd1;
               cmd.advance = (hold_ff == 2'd1);
            end else if (win[sts_pkg::SEND_COUNT+2] == sts_pkg::MARKER_BYTE) begin
               hold_in = sts_pkg::HOLD_FRAMES;
            end else if (win[sts_pkg::SEND_COUNT+1] == 8'd0) begin
               cmd.restart = 1'b1;
            end else begin
               cmd.advance = 1'b1;
            end
         end
      end

      result.send_strobe    = strobe;
      result.send_byte      = sent_byte;
      result.select_active  = select_in;
      result.left_char      = left_in;
      result.right_char     = right_in;
      result.sweep_column   = col_in;
      result.normal_running = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= 1'b0;
         down_ff   <= 1'b0;
         pace_ff   <= sts_pkg::PACE_RESET;
         col_ff    <= '0;
         sent_ff   <= '0;
         hold_ff   <= '0;
         left_ff   <= '0;
         right_ff  <= '0;
         select_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         down_ff   <= down_in;
         pace_ff   <= pace_in;
         col_ff    <= col_in;
         sent_ff   <= sent_in;
         hold_ff   <= hold_in;
         left_ff   <= left_in;
         right_ff  <= right_in;
         select_ff <= select_in;
      end
   end

   // transfers only run in the scrolling phase
   a_select_phase: assert property (@(posedge clock) disable iff (reset)
      select_ff |-> phase_ff)
      else $error("chain select outside scrolling phase");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= sts_pkg::LAST_COLUMN)
      else $error("sweep column past last column");

   a_sent_range: assert property (@(posedge clock) disable iff (reset)
      sent_ff <= sts_pkg::SENT_W'(sts_pkg::SEND_COUNT + 2))
      else $error("push count out of range");

   a_hold_clear: assert property (@(posedge clock) disable iff (reset)
      (hold_ff != 2'd0) |->
         (phase_ff && !select_ff || sent_ff <= sts_pkg::SENT_W'(sts_pkg::SEND_COUNT)))
      else $error("hold pending outside scrolling");

endmodule

/* sv/scrolling_text_sequencer_core.sv */
// top level of the scroll sequencer: request and response registers, pace register
// flow: a taken request waits in the input register until it fires, and its response is then registered for output
// throughput: one request per cycle; a stalled response holds one more in the input register
// reset: synchronous, clears control state, pace register to 16, characters and column to 0
// the message store keeps its contents over reset and is not cleared
module scrolling_text_sequencer_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sts_pkg::sts_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sts_pkg::sts_rsp_type rsp_data,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data
);

   logic                     req_v_ff, req_v_in;
   sts_pkg::sts_req_type     req_item_ff;
   logic                     rsp_v_ff, rsp_v_in;
   sts_pkg::sts_rsp_type     rsp_item_ff;
   logic [7:0]               pace_cfg_ff;
   logic                     fire;
   logic                     take;
   sts_pkg::sts_win_cmd_type cmd;
   sts_pkg::sts_win_type     win;
   sts_pkg::sts_rsp_type     result;

   assign fire      = req_v_ff && (!rsp_v_ff || !rsp_stall);
   assign req_stall = req_v_ff && !fire;
   assign take      = req_valid && !req_stall;

   always_comb begin
      if (take) begin
         req_v_in = 1'b1;
      end else if (fire) begin
         req_v_in = 1'b0;
      end else begin
         req_v_in = req_v_ff;
      end
      if (fire) begin
         rsp_v_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_v_in = 1'b0;
      end else begin
         rsp_v_in = rsp_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_v_ff    <= 1'b0;
         rsp_v_ff    <= 1'b0;
         pace_cfg_ff <= sts_pkg::PACE_RESET;
      end else begin
         req_v_ff <= req_v_in;
         rsp_v_ff <= rsp_v_in;
         if (csr_wr_en) begin
            pace_cfg_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_item_ff <= req_data;
      end
      if (fire) begin
         rsp_item_ff <= result;
      end
   end

   sts_control u_control (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .req      (req_item_ff),
      .pace_cfg (pace_cfg_ff),
      .win      (win),
      .cmd      (cmd),
      .result   (result)
   );

   sts_window u_window (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .win   (win)
   );

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_item_ff;

endmodule
